// ----- rtl/core/bal_pkg.sv -----
// shared types and constants for the bounded array list
`default_nettype none

package bal_pkg;

	// fixed field widths of the command and result words
	localparam int CNT_W  = 7;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int SLOT_W = 6;
	localparam int CMD_W  = 3;

	// capacity limit after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET     = 3'd0,
		CMD_SET     = 3'd1,
		CMD_APPEND  = 3'd2,
		CMD_INSERT  = 3'd3,
		CMD_REMOVE  = 3'd4,
		CMD_CLEAR   = 3'd5,
		CMD_RESERVE = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BOUNDS   = 2'd1,
		ST_CAPACITY = 2'd2
	} status_t;

	// how a command finishes once decoded
	typedef enum logic [1:0] {
		PATH_NOW  = 2'd0,
		PATH_GET  = 2'd1,
		PATH_MOVE = 2'd2
	} path_t;

	typedef enum logic [1:0] {
		S_IDLE     = 2'd0,
		S_GET_WAIT = 2'd1,
		S_MOVE_RD  = 2'd2,
		S_MOVE_WR  = 2'd3
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic get_fin;
		logic move_wr;
		logic move_fin;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		path_t path;
		logic  move_last;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/bal_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/bal_ctrl.sv -----
// command sequencer for the bounded array list
`default_nettype none

module bal_ctrl
	import bal_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output ctl_t      ctl,
	input  wire sts_t sts
);

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   done_d;

	// state and strobe registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					unique case (sts.path)
						PATH_GET:  state_d = S_GET_WAIT;
						PATH_MOVE: state_d = S_MOVE_RD;
						default:   done_d  = 1'b1;
					endcase
				end
			end
			S_GET_WAIT: begin
				ctl.get_fin = 1'b1;
				done_d      = 1'b1;
				state_d     = S_IDLE;
			end
			S_MOVE_RD: begin
				if (sts.move_last) begin
					ctl.move_fin = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_MOVE_WR;
				end
			end
			S_MOVE_WR: begin
				ctl.move_wr = 1'b1;
				state_d     = S_MOVE_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// an accepted word either finishes at once or keeps the block busy
	a_accept_resolves: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted word neither finished nor in progress");

	// every shift write is followed by the next shift read
	a_wr_then_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE_WR |=> state_q == S_MOVE_RD)
		else $error("shift write not followed by shift read");

endmodule

`default_nettype wire

// ----- rtl/core/bal_dp.sv -----
// datapath: entry store, count, capacity register, decode and result registers
`default_nettype none

module bal_dp
	import bal_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctl_t              ctl,
	output sts_t                   sts,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [VAL_W-1:0]  write_value,
	input  wire logic              cfg_write,
	input  wire logic [CNT_W-1:0]  cfg_data,
	output logic      [1:0]        status,
	output logic      [VAL_W-1:0]  read_value,
	output logic      [SLOT_W-1:0] slot_index,
	output logic      [CNT_W-1:0]  entry_count
);

	localparam int AW     = $clog2(DEPTH);
	localparam int LimMax = (DEPTH > 127) ? 127 : DEPTH;

	cmd_t                   cmd_in;
	cmd_t                   cmd_q;
	logic [POS_W-1:0]       pos_q;
	logic [ENTRY_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       cap_q;
	logic [CNT_W-1:0]       lim;
	logic                   full;
	logic                   is_ins;

	status_t                dec_status;
	path_t                  dec_path;
	logic                   dec_we;
	logic [CNT_W-1:0]       dec_widx;
	logic [CNT_W-1:0]       dec_count;
	logic [SLOT_W-1:0]      dec_slot;

	logic                   ram_we;
	logic [CNT_W-1:0]       ram_widx;
	logic [ENTRY_WIDTH-1:0] ram_wdata;
	logic [CNT_W-1:0]       ram_ridx;
	logic [ENTRY_WIDTH-1:0] ram_rdata;

	status_t                status_q;
	logic [VAL_W-1:0]       rv_q;
	logic [SLOT_W-1:0]      slot_q;

	assign cmd_in = cmd_t'(command);
	assign is_ins = (cmd_q == CMD_INSERT);

	// limit in force saturates at the store depth
	assign lim  = (cap_q > CNT_W'(LimMax)) ? CNT_W'(LimMax) : cap_q;
	assign full = (count_q >= lim);

	// command decode against the current count
	always_comb begin
		dec_status = ST_OK;
		dec_path   = PATH_NOW;
		dec_we     = 1'b0;
		dec_widx   = count_q;
		dec_count  = count_q;
		dec_slot   = '0;
		unique case (cmd_in)
			CMD_GET: begin
				if (position >= count_q) dec_status = ST_BOUNDS;
				else                     dec_path   = PATH_GET;
			end
			CMD_SET: begin
				if (position >= count_q) begin
					dec_status = ST_BOUNDS;
				end else begin
					dec_we   = 1'b1;
					dec_widx = position;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					dec_status = ST_CAPACITY;
				end else begin
					dec_we    = 1'b1;
					dec_count = count_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (full)                   dec_status = ST_CAPACITY;
				else if (position > count_q) dec_status = ST_BOUNDS;
				else                        dec_path   = PATH_MOVE;
			end
			CMD_REMOVE: begin
				if (position >= count_q) dec_status = ST_BOUNDS;
				else                     dec_path   = PATH_MOVE;
			end
			CMD_CLEAR: dec_count = '0;
			CMD_RESERVE: begin
				if (full) begin
					dec_status = ST_CAPACITY;
				end else begin
					dec_slot  = SLOT_W'(count_q);
					dec_count = count_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// status toward the controller
	assign sts.path      = dec_path;
	assign sts.move_last = is_ins ? (idx_q == pos_q) : ((idx_q + CNT_W'(1)) == count_q);

	// store write port select
	always_comb begin
		ram_we    = 1'b0;
		ram_widx  = dec_widx;
		ram_wdata = ENTRY_WIDTH'(write_value);
		if (ctl.accept && (dec_path == PATH_NOW) && dec_we) begin
			ram_we = 1'b1;
		end else if (ctl.move_wr) begin
			ram_we    = 1'b1;
			ram_widx  = idx_q;
			ram_wdata = ram_rdata;
		end else if (ctl.move_fin && is_ins) begin
			ram_we    = 1'b1;
			ram_widx  = pos_q;
			ram_wdata = val_q;
		end
	end

	// store read address: get position, or the neighbor of the shift index
	assign ram_ridx = ctl.accept ? position :
		(is_ins ? (idx_q - CNT_W'(1)) : (idx_q + CNT_W'(1)));

	bal_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(ram_widx)),
		.wdata (ram_wdata),
		.raddr (AW'(ram_ridx)),
		.rdata (ram_rdata)
	);

	// count and capacity limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_write) begin
				cap_q <= cfg_data;
			end
			if (ctl.accept && (dec_path == PATH_NOW)) begin
				count_q <= dec_count;
			end else if (ctl.move_fin) begin
				count_q <= is_ins ? (count_q + CNT_W'(1)) : (count_q - CNT_W'(1));
			end
		end
	end

	// captured command word and shift index
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= cmd_in;
			pos_q <= position;
			val_q <= ENTRY_WIDTH'(write_value);
			idx_q <= (cmd_in == CMD_INSERT) ? count_q : position;
		end else if (ctl.move_wr) begin
			idx_q <= is_ins ? (idx_q - CNT_W'(1)) : (idx_q + CNT_W'(1));
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctl.accept && (dec_path == PATH_NOW)) begin
			status_q <= dec_status;
			rv_q     <= '0;
			slot_q   <= dec_slot;
		end else if (ctl.get_fin) begin
			status_q <= ST_OK;
			rv_q     <= VAL_W'(ram_rdata);
			slot_q   <= '0;
		end else if (ctl.move_fin) begin
			status_q <= ST_OK;
			rv_q     <= '0;
			slot_q   <= '0;
		end
	end

	assign status      = status_q;
	assign read_value  = rv_q;
	assign slot_index  = slot_q;
	assign entry_count = count_q;

	// the count never passes the largest possible limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LimMax))
		else $error("entry count above store limit");

	// a finished insert grows the list by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.move_fin && is_ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

endmodule

`default_nettype wire

// ----- rtl/core/bounded_array_list.sv -----
// top level of the bounded array list
//
// Ordered list of up to the capacity limit (saturated at the store depth) entries held in a single-port-write RAM.
// Command channel: command, position and write_value are taken at a clock edge
// where start is high and busy is low. Each word gives one result, shown for
// exactly one cycle with done high on status, read_value, slot_index and
// entry_count; the receiver cannot stall, so the result must be taken then.
// Config channel: cfg_data is written into the capacity limit when cfg_valid
// and cfg_ready are high; cfg_ready is always high. Write it only when idle.
// Set, append, clear, reserve and any rejected command finish straight from
// decode; get waits on the registered RAM read; insert and remove shift the
// entries from position to the end of the list, moving one entry per pass
// through the read and write shift states. A new word may be accepted in the
// cycle that done is high. Reset clears the count to zero and sets the
// capacity limit to 64; entry contents are undefined until written.
`default_nettype none

module bounded_array_list
	import bal_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [VAL_W-1:0]  write_value,
	output logic                   done,
	output logic      [1:0]        status,
	output logic      [VAL_W-1:0]  read_value,
	output logic      [SLOT_W-1:0] slot_index,
	output logic      [CNT_W-1:0]  entry_count,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CNT_W-1:0]  cfg_data
);

	ctl_t ctl;
	sts_t sts;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	// controller
	bal_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	// datapath
	bal_dp #(
		.DEPTH       (DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.position    (position),
		.write_value (write_value),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.status      (status),
		.read_value  (read_value),
		.slot_index  (slot_index),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire

// ----- dv/bounded_array_list_tb.sv -----
// testbench for the bounded array list: directed and random list commands checked against a predictor

module bounded_array_list_tb;
	import bal_pkg::*;

	localparam int LIST_DEPTH  = 64;
	localparam int TOTAL_ITEMS = 1150;
	localparam int TAIL_CYCLES = 140;

	// command code outside the defined set, must be ignored
	localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

	// which copy of the list state a prediction works on
	localparam int PLAN = 0;
	localparam int LIVE = 1;

	// command mix of a random phase
	localparam int P_FILL   = 0;
	localparam int P_GROW   = 1;
	localparam int P_SHRINK = 2;
	localparam int P_MIXED  = 3;
	localparam int P_NOISE  = 4;

	// sender idling style of a random phase
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_FULL   = 1;
	localparam int IDLE_SPARSE = 2;

	typedef enum logic [1:0] {
		W_CMD   = 2'd0,
		W_CFG   = 2'd1,
		W_DRAIN = 2'd2
	} work_kind_t;

	typedef struct packed {
		work_kind_t         kind;
		logic [CMD_W-1:0]   op;
		logic [POS_W-1:0]   pos;
		logic [VAL_W-1:0]   val;
		logic [CNT_W-1:0]   cap;
		logic [4:0]         gap;
	} work_t;

	typedef struct packed {
		status_t            st;
		logic [VAL_W-1:0]   rd;
		logic [SLOT_W-1:0]  slot;
		logic [CNT_W-1:0]   cnt;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CMD_W-1:0] command = '0;
	logic [POS_W-1:0] position = '0;
	logic [VAL_W-1:0] write_value = '0;
	logic cfg_valid = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;

	logic busy;
	logic done;
	logic [1:0] status;
	logic [VAL_W-1:0] read_value;
	logic [SLOT_W-1:0] slot_index;
	logic [CNT_W-1:0] entry_count;
	logic cfg_ready;

	// list state: one copy for planning stimulus, one tracking the block
	logic [VAL_W-1:0] slot_data [2][LIST_DEPTH];
	bit slot_known [2][LIST_DEPTH];
	int list_len [2];
	int cap_setting [2];

	work_t cmd_backlog [$];
	list_result_t expected_results [$];

	logic cmd_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int gap_left = 0;
	bit gap_loaded = 1'b0;
	int idle_mode = IDLE_SPARSE;
	int items_queued = 0;
	int error_count = 0;

	bounded_array_list #(
		.DEPTH(LIST_DEPTH),
		.ENTRY_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.write_value(write_value),
		.done(done),
		.status(status),
		.read_value(read_value),
		.slot_index(slot_index),
		.entry_count(entry_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one command to a copy of the list and gives the result word
	function automatic list_result_t predict_list_op(input int side,
			input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		list_result_t res;
		int n;
		int lim;
		int i;
		bit full;
		n = list_len[side];
		lim = (cap_setting[side] > LIST_DEPTH) ? LIST_DEPTH : cap_setting[side];
		full = (n >= lim);
		res.st = ST_OK;
		res.rd = '0;
		res.slot = '0;
		case (op)
			CMD_GET: begin
				if (pos >= n)
					res.st = ST_BOUNDS;
				else
					res.rd = slot_data[side][pos];
			end
			CMD_SET: begin
				if (pos >= n) begin
					res.st = ST_BOUNDS;
				end else begin
					slot_data[side][pos] = val;
					slot_known[side][pos] = 1'b1;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					res.st = ST_CAPACITY;
				end else begin
					slot_data[side][n] = val;
					slot_known[side][n] = 1'b1;
					n++;
				end
			end
			CMD_INSERT: begin
				// capacity is checked ahead of the index
				if (full) begin
					res.st = ST_CAPACITY;
				end else if (pos > n) begin
					res.st = ST_BOUNDS;
				end else begin
					for (i = n; i > pos; i--) begin
						slot_data[side][i] = slot_data[side][i-1];
						slot_known[side][i] = slot_known[side][i-1];
					end
					slot_data[side][pos] = val;
					slot_known[side][pos] = 1'b1;
					n++;
				end
			end
			CMD_REMOVE: begin
				if (pos >= n) begin
					res.st = ST_BOUNDS;
				end else begin
					for (i = pos; i + 1 < n; i++) begin
						slot_data[side][i] = slot_data[side][i+1];
						slot_known[side][i] = slot_known[side][i+1];
					end
					n--;
				end
			end
			CMD_CLEAR: n = 0;
			CMD_RESERVE: begin
				// the slot keeps whatever it held
				if (full) begin
					res.st = ST_CAPACITY;
				end else begin
					res.slot = n[SLOT_W-1:0];
					n++;
				end
			end
			default: ;
		endcase
		list_len[side] = n;
		res.cnt = n[CNT_W-1:0];
		return res;
	endfunction

	function automatic logic [4:0] draw_gap();
		case (idle_mode)
			IDLE_NONE: return 5'd0;
			IDLE_FULL: return 5'($urandom_range(0, 18));
			default: return ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 18)) : 5'd0;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_op(input int profile);
		int roll;
		roll = $urandom_range(0, 99);
		case (profile)
			P_FILL: begin
				if (roll < 70) return CMD_APPEND;
				if (roll < 85) return CMD_RESERVE;
				if (roll < 95) return CMD_GET;
				return CMD_SET;
			end
			P_GROW: begin
				if (roll < 30) return CMD_APPEND;
				if (roll < 55) return CMD_INSERT;
				if (roll < 65) return CMD_RESERVE;
				if (roll < 80) return CMD_GET;
				if (roll < 92) return CMD_SET;
				return CMD_REMOVE;
			end
			P_SHRINK: begin
				if (roll < 45) return CMD_REMOVE;
				if (roll < 65) return CMD_GET;
				if (roll < 75) return CMD_SET;
				if (roll < 90) return CMD_INSERT;
				if (roll < 97) return CMD_APPEND;
				return CMD_CLEAR;
			end
			P_MIXED: begin
				if (roll < 15) return CMD_GET;
				if (roll < 30) return CMD_SET;
				if (roll < 45) return CMD_APPEND;
				if (roll < 60) return CMD_INSERT;
				if (roll < 78) return CMD_REMOVE;
				if (roll < 90) return CMD_RESERVE;
				if (roll < 93) return CMD_CLEAR;
				if (roll < 96) return CMD_SPARE;
				return CMD_GET;
			end
			default: return CMD_W'($urandom_range(0, 7));
		endcase
	endfunction

	// mostly in range, with the edges of the list and some wild indexes
	function automatic logic [POS_W-1:0] pick_pos(input logic [CMD_W-1:0] op,
			input int profile);
		int n;
		n = list_len[PLAN];
		if (profile == P_NOISE || $urandom_range(0, 11) == 0)
			return POS_W'($urandom_range(0, 127));
		case ($urandom_range(0, 7))
			0: return POS_W'(n);
			1: return (n == 0) ? POS_W'(0) : POS_W'(n - 1);
			2: return POS_W'(n + 1);
			default: begin
				if (op == CMD_INSERT)
					return POS_W'($urandom_range(0, n));
				return (n == 0) ? POS_W'(0) : POS_W'($urandom_range(0, n - 1));
			end
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_cap();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd2;
			3: return CNT_W'(list_len[PLAN]);
			4: return CNT_W'(list_len[PLAN] / 2);
			5: return 7'd63;
			6: return 7'd64;
			7: return 7'd65;
			8: return 7'd127;
			default: return CNT_W'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		work_t w;
		logic [CMD_W-1:0] o;
		o = op;
		// never read a slot that was never written
		if (o == CMD_GET && pos < list_len[PLAN] && !slot_known[PLAN][pos])
			o = CMD_SET;
		void'(predict_list_op(PLAN, o, pos, val));
		w.kind = W_CMD;
		w.op = o;
		w.pos = pos;
		w.val = val;
		w.cap = '0;
		w.gap = draw_gap();
		cmd_backlog.push_back(w);
		items_queued++;
	endtask

	task automatic push_cfg(input logic [CNT_W-1:0] cap);
		work_t w;
		cap_setting[PLAN] = cap;
		w = '0;
		w.kind = W_CFG;
		w.cap = cap;
		w.gap = draw_gap();
		cmd_backlog.push_back(w);
	endtask

	task automatic push_drain();
		work_t w;
		w = '0;
		w.kind = W_DRAIN;
		cmd_backlog.push_back(w);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// driver: presents one queued word at a time, holds it until taken
	always @(negedge clk) begin : drive
		logic keep_start;
		logic keep_cfg;
		work_t head;
		if (arst_n) begin
			keep_start = start && !cmd_taken;
			keep_cfg = cfg_valid && !cfg_taken;
			if (!keep_start && !keep_cfg && cmd_backlog.size() != 0) begin
				head = cmd_backlog[0];
				if (!gap_loaded) begin
					gap_left = head.gap;
					gap_loaded = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else if (head.kind == W_CMD) begin
					keep_start = 1'b1;
					command <= head.op;
					position <= head.pos;
					write_value <= head.val;
					void'(cmd_backlog.pop_front());
					gap_loaded = 1'b0;
				end else if (expected_results.size() == 0) begin
					// register writes and pauses only with the block idle
					if (head.kind == W_CFG) begin
						keep_cfg = 1'b1;
						cfg_data <= head.cap;
					end
					void'(cmd_backlog.pop_front());
					gap_loaded = 1'b0;
				end
			end
			start <= keep_start;
			cfg_valid <= keep_cfg;
		end
	end

	// monitor: checks result words, predicts each accepted word
	always @(posedge clk or negedge arst_n) begin : observe
		list_result_t want;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
			cfg_taken <= 1'b0;
			list_len[LIVE] = 0;
			cap_setting[LIVE] = CAP_RESET;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: result word with nothing expected, status %0d count %0d",
						$time, status, entry_count);
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.st, status);
					check_field("read_value", want.rd, read_value);
					check_field("slot_index", want.slot, slot_index);
					check_field("entry_count", want.cnt, entry_count);
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_list_op(LIVE, command, position,
					write_value));
			if (cfg_valid && cfg_ready)
				cap_setting[LIVE] = cfg_data;
			cmd_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;
		end
	end

	initial begin : stimulus
		int k;
		int profile;
		int span;
		logic [CMD_W-1:0] op;
		for (k = 0; k < 2; k++) begin
			list_len[k] = 0;
			cap_setting[k] = CAP_RESET;
		end
		for (k = 0; k < LIST_DEPTH; k++)
			slot_known[PLAN][k] = 1'b0;

		// directed: empty list edges, shifts, reserve, capacity limits
		idle_mode = IDLE_SPARSE;
		push_cfg(CAP_RESET);
		push_cmd(CMD_GET, 7'd0, 32'h0);
		push_cmd(CMD_SET, 7'd0, 32'h1111_1111);
		push_cmd(CMD_REMOVE, 7'd0, 32'h0);
		push_cmd(CMD_INSERT, 7'd1, 32'h2222_2222);
		push_cmd(CMD_SPARE, 7'd127, 32'hFFFF_FFFF);
		push_cmd(CMD_CLEAR, 7'd0, 32'h0);
		push_cmd(CMD_APPEND, 7'd0, 32'hFFFF_FFFF);
		push_cmd(CMD_APPEND, 7'd127, 32'h0);
		push_cmd(CMD_INSERT, 7'd0, 32'hA5A5_A5A5);
		push_cmd(CMD_INSERT, 7'd3, 32'h5A5A_5A5A);
		push_cmd(CMD_INSERT, 7'd127, 32'h3333_3333);
		push_cmd(CMD_GET, 7'd0, 32'h0);
		push_cmd(CMD_GET, 7'd3, 32'h0);
		push_cmd(CMD_GET, 7'd127, 32'h0);
		push_cmd(CMD_SET, 7'd1, 32'h1234_5678);
		push_cmd(CMD_REMOVE, 7'd0, 32'h0);
		push_cmd(CMD_GET, 7'd0, 32'h0);
		push_cmd(CMD_REMOVE, 7'd2, 32'h0);
		push_cmd(CMD_RESERVE, 7'd0, 32'h0);
		push_cmd(CMD_GET, 7'd2, 32'h0);
		// limit equal to the count
		push_cfg(7'd3);
		push_cmd(CMD_APPEND, 7'd0, 32'h4444_4444);
		push_cmd(CMD_INSERT, 7'd127, 32'h5555_5555);
		push_cmd(CMD_RESERVE, 7'd0, 32'h0);
		// limit below the count: held entries still usable
		push_cfg(7'd0);
		push_cmd(CMD_GET, 7'd0, 32'h0);
		push_cmd(CMD_SET, 7'd2, 32'h6666_6666);
		push_cmd(CMD_REMOVE, 7'd1, 32'h0);
		push_cmd(CMD_APPEND, 7'd0, 32'h7777_7777);
		push_drain();

		// random phases, first one fills the list up to a saturated limit
		k = 0;
		while (items_queued < TOTAL_ITEMS) begin
			if (k == 0) begin
				push_cfg(7'd127);
				profile = P_FILL;
				span = 80;
			end else begin
				if ($urandom_range(0, 1))
					push_cfg(pick_cap());
				else if ($urandom_range(0, 3) == 0)
					push_drain();
				case ($urandom_range(0, 9))
					0: profile = P_FILL;
					1, 2, 3: profile = P_GROW;
					4, 5: profile = P_SHRINK;
					6, 7, 8: profile = P_MIXED;
					default: profile = P_NOISE;
				endcase
				span = $urandom_range(15, 60);
			end
			idle_mode = $urandom_range(0, 2);
			repeat (span) begin
				op = pick_op(profile);
				push_cmd(op, pick_pos(op, profile), rand_word());
			end
			k++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start || cfg_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/bal_pkg.sv
rtl/core/bal_ram.sv
rtl/core/bal_ctrl.sv
rtl/core/bal_dp.sv
rtl/core/bounded_array_list.sv
dv/bounded_array_list_tb.sv
